// ===== rtl/core/base64_stream_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared concurrent assertion forms used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared constants, types and the sextet-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // Complete 3-byte groups per output line before CR LF is inserted.
    localparam int GROUPS_PER_LINE = 16;
    localparam int GPL_W = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;

    // Most characters that one input byte can produce.
    localparam int MAX_CHARS = 4;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int PTR_W     = $clog2(MAX_CHARS);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_DIGIT = 8'h30;

    // Position codes of the next byte within its 3-byte group.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    // Characters produced by one byte, in emission order, and their count.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
    } t_burst;

    // Maps a 6-bit value to its Base64 alphabet character.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            sextet_char = CH_UPPER + w;
        end else if (v < 6'd52) begin
            sextet_char = CH_LOWER + (w - 8'd26);
        end else if (v < 6'd62) begin
            sextet_char = CH_DIGIT + (w - 8'd52);
        end else if (v == 6'd62) begin
            sextet_char = CH_PLUS;
        end else begin
            sextet_char = CH_SLASH;
        end
    endfunction

endpackage

// ===== rtl/core/b64e_if.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder channel interfaces
// Valid/ready channels for raw input bytes and encoded output characters.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== rtl/core/b64e_encode.sv =====
// ----------------------------------------------------------------------------
// Base64 byte encoder
// Holds the group state and turns one byte into its burst of characters.
// ----------------------------------------------------------------------------
module b64e_encode
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output t_burst     o_burst
);

    logic [1:0]       r_pos;
    logic [3:0]       r_held;
    logic [GPL_W-1:0] r_gol;
    logic [1:0]       n_pos;
    logic [3:0]       n_held;
    logic [GPL_W-1:0] n_gol;
    logic             line_full;

    // The group being finished fills the line when the count is at its top.
    assign line_full = (r_gol == GPL_W'(GROUPS_PER_LINE - 1));

    always_comb begin
        o_burst.chars = '0;
        o_burst.cnt   = '0;
        n_pos         = r_pos;
        n_held        = r_held;
        n_gol         = r_gol;
        priority if (r_pos == POS_SECOND) begin
            o_burst.chars[0] = sextet_char({r_held[1:0], i_byte[7:4]});
            o_burst.cnt      = CNT_W'(1);
            n_held           = i_byte[3:0];
            n_pos            = POS_THIRD;
            if (i_final) begin
                o_burst.chars[1] = sextet_char({i_byte[3:0], 2'b00});
                o_burst.chars[2] = CH_PAD;
                o_burst.cnt      = CNT_W'(3);
            end
        end else if (r_pos == POS_THIRD) begin
            o_burst.chars[0] = sextet_char({r_held, i_byte[7:6]});
            o_burst.chars[1] = sextet_char(i_byte[5:0]);
            o_burst.cnt      = CNT_W'(2);
            n_held           = 4'd0;
            n_pos            = POS_FIRST;
            n_gol            = r_gol + GPL_W'(1);
            if (line_full) begin
                o_burst.chars[2] = CH_CR;
                o_burst.chars[3] = CH_LF;
                o_burst.cnt      = CNT_W'(4);
                n_gol            = '0;
            end
        end else begin
            // First byte of a group; the unused position code lands here too.
            o_burst.chars[0] = sextet_char(i_byte[7:2]);
            o_burst.cnt      = CNT_W'(1);
            n_held           = {2'b00, i_byte[1:0]};
            n_pos            = POS_SECOND;
            if (i_final) begin
                o_burst.chars[1] = sextet_char({i_byte[1:0], 4'b0000});
                o_burst.chars[2] = CH_PAD;
                o_burst.chars[3] = CH_PAD;
                o_burst.cnt      = CNT_W'(4);
            end
        end
        // The final byte of a message returns the encoder to its start state.
        if (i_final) begin
            n_pos  = POS_FIRST;
            n_held = 4'd0;
            n_gol  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_FIRST;
            r_held <= 4'd0;
            r_gol  <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_held <= n_held;
            r_gol  <= n_gol;
        end
    end

endmodule

// ===== rtl/core/b64e_serial.sv =====
// ----------------------------------------------------------------------------
// Base64 character serializer
// Holds one burst and sends it out one character per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_serial
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_char,
    output logic       o_last,
    input  logic       i_out_ready
);

    logic [MAX_CHARS-1:0][7:0] r_buf;
    logic [CNT_W-1:0]          r_left;
    logic [PTR_W-1:0]          r_ptr;
    logic                      r_out_valid;
    logic [7:0]                r_out_char;
    logic                      r_out_last;
    logic                      out_free;
    logic                      advance;

    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = out_free && (r_left != '0);

    // A new burst may enter once the held one is empty or sends its last
    // character in this cycle.
    assign o_ready = (r_left == '0) || ((r_left == CNT_W'(1)) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ptr  <= '0;
        end else if (i_load) begin
            r_left <= i_burst.cnt;
            r_ptr  <= '0;
        end else if (advance) begin
            r_left <= r_left - CNT_W'(1);
            r_ptr  <= r_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_burst.chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (r_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= r_buf[r_ptr];
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    `B64E_ASSERT_NOW(a_left_range, i_clk, i_rst_n, 1'b1, r_left <= CNT_W'(MAX_CHARS), "burst count above four")
    `B64E_ASSERT_NOW(a_burst_nonempty, i_clk, i_rst_n, i_load, i_burst.cnt != '0, "byte produced no characters")
    `B64E_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, i_load, (r_left == $past(i_burst.cnt)) && (r_ptr == '0), "burst not loaded")
    `B64E_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, advance && (r_left == CNT_W'(1)) && !i_load, r_out_last && (r_left == '0), "last mark misplaced")

endmodule

// ===== rtl/core/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder with line wrap
// Encodes a byte stream into Base64 characters with CR LF every 64 characters.
// ----------------------------------------------------------------------------
// Usage: raw bytes enter on i_in (in_byte, is_final) and characters leave on
// o_out (out_char, last_of_run); both are valid/ready channels and a transfer
// happens at each rising edge with valid and ready high. Mark the last byte of
// a message with is_final so an open group is closed with '=' padding.
// Each byte gives one to four characters: one or two for data, plus one or two
// pad characters on a final partial group, or CR LF after a line of 16 groups.
// last_of_run flags the final character that a given byte caused.
// The first character of a byte passes through the burst buffer, loaded at the
// byte transfer, and then the output register. Throughput is one character per
// cycle while the receiver is ready, set by the single output register.
// The next byte is taken in the same cycle in which the previous byte's last
// character moves to the output register, so no bubbles appear between bytes.
// Reset clears the group position, held bits and line count and empties the
// output. When the receiver stalls, the output register holds its character,
// the burst buffer holds the rest, and i_in.ready drops until space frees up.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_in,
    b64e_char_if.source o_out
);

    t_burst burst;
    logic   ser_ready;
    logic   in_accept;

    // A byte is encoded and its characters loaded in the transfer cycle.
    assign i_in.ready = ser_ready;
    assign in_accept  = i_in.valid && ser_ready;

    b64e_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .i_final  (i_in.is_final),
        .o_burst  (burst)
    );

    // The serializer keeps the burst and drives the registered output.
    b64e_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_burst     (burst),
        .o_ready     (ser_ready),
        .o_valid     (o_out.valid),
        .o_char      (o_out.out_char),
        .o_last      (o_out.last_of_run),
        .i_out_ready (o_out.ready)
    );

endmodule
